// ===== hw/rtl/mfrdp_pkg.sv =====
// Package for the mixed-format row dot product unit.
// Holds format codes, the queue item type and binary32 helper functions.
// No dependencies.
package mfrdp_pkg;

  localparam logic [1:0] FMT_FP32 = 2'd0;
  localparam logic [1:0] FMT_BF16 = 2'd1;
  localparam logic [1:0] FMT_HALF = 2'd2;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [31:0] prod;
    logic        last;
  } prod_item_t;

  typedef struct packed {
    logic [2:0] level;
  } queue_stat_t;

  function automatic logic is_nan(logic [31:0] b);
    return b[30:0] > INF_BITS[30:0];
  endfunction

  function automatic logic is_inf(logic [31:0] b);
    return b[30:0] == INF_BITS[30:0];
  endfunction

  function automatic logic is_zero(logic [31:0] b);
    return b[30:0] == 31'd0;
  endfunction

  function automatic logic [63:0] shr_jam(logic [63:0] x, logic [7:0] n);
    logic [63:0] mask;
    mask = 64'd0;
    if (n == 8'd0) return x;
    if (n >= 8'd64) return {63'd0, |x};
    mask = (64'd1 << n[5:0]) - 64'd1;
    return (x >> n[5:0]) | {63'd0, |(x & mask)};
  endfunction

  // value = sig * 2^(e - 150), sig nonzero and below 2^63
  function automatic logic [31:0] round_pack(logic s, logic signed [11:0] e,
                                             logic [63:0] sig);
    logic [5:0]         p;
    logic [5:0]         sh;
    logic [63:0]        nsig;
    logic signed [11:0] be;
    logic signed [11:0] d;
    logic [24:0]        keep;
    logic [38:0]        rem;
    logic [33:0]        bits;
    p = 6'd0;
    for (int i = 0; i < 63; i++) begin
      if (sig[i]) p = 6'(i);
    end
    sh   = 6'd62 - p;
    nsig = sig << sh;
    be   = e - 12'(sh) + 12'sd39;
    if (be < 12'sd1) begin
      d = 12'sd1 - be;
      nsig = shr_jam(nsig, (d > 12'sd64) ? 8'd64 : d[7:0]);
      be = 12'sd1;
    end
    keep = nsig[63:39];
    rem  = nsig[38:0];
    if (rem > {1'b1, 38'd0} || (rem == {1'b1, 38'd0} && keep[0])) keep = keep + 25'd1;
    bits = ({22'd0, be - 12'sd1} << 23) + {9'd0, keep};
    if (bits >= {2'b00, INF_BITS}) bits = {2'b00, INF_BITS};
    return {s, bits[30:0]};
  endfunction

  function automatic logic [31:0] half_to_single(logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] k;
    logic [22:0] fm;
    e = h[14:10];
    m = h[9:0];
    k = 4'd0;
    fm = 23'd0;
    if (e == 5'd0) begin
      if (m == 10'd0) return {h[15], 31'd0};
      for (int i = 0; i < 10; i++) begin
        if (m[i]) k = 4'(i);
      end
      fm = {13'd0, m} << (5'd23 - {1'b0, k});
      return {h[15], 8'(k) + 8'd103, fm};
    end
    if (e == 5'd31) return {h[15], 8'hFF, m, 13'd0};
    return {h[15], 8'(e) + 8'd112, m, 13'd0};
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [31:0]  x;
    logic [31:0]  y;
    logic [7:0]   ex;
    logic [7:0]   ey;
    logic [63:0]  mx;
    logic [63:0]  my;
    logic [63:0]  r;
    if (is_nan(a) || is_nan(b)) return QNAN_BITS;
    if (is_inf(a) || is_inf(b)) begin
      if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return QNAN_BITS;
      return is_inf(a) ? a : b;
    end
    if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
    if (is_zero(a)) return b;
    if (is_zero(b)) return a;
    if (a[30:0] < b[30:0]) begin
      x = b; y = a;
    end else begin
      x = a; y = b;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {8'd0, x[30:23] != 8'd0, x[22:0], 32'd0};
    my = {8'd0, y[30:23] != 8'd0, y[22:0], 32'd0};
    my = shr_jam(my, ex - ey);
    r  = (x[31] == y[31]) ? mx + my : mx - my;
    if (r == 64'd0) return 32'd0;
    return round_pack(x[31], 12'(ex) - 12'sd32, r);
  endfunction

endpackage

// ===== hw/rtl/mfrdp_front.sv =====
// Front end: weight decode, binary32 multiply and product rounding.
// Two pipeline stages; depends on mfrdp_pkg.
module mfrdp_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [31:0]              weight_word_i,
  input  logic [31:0]              activation_bits_i,
  input  logic                     row_end_i,
  input  logic [1:0]               fmt_i,
  input  mfrdp_pkg::queue_stat_t   qstat_i,
  output logic                     qpush_o,
  output mfrdp_pkg::prod_item_t    qitem_o
);
  import mfrdp_pkg::*;

  logic               s1_vld_q, s2_vld_q;
  logic               s1_spec_q, s1_sign_q, s1_last_q;
  logic [31:0]        s1_sval_q;
  logic signed [11:0] s1_exp_q;
  logic [47:0]        s1_sig_q;
  prod_item_t         s2_q;
  logic               acc;
  logic [31:0]        w, x;
  logic               spec_d;
  logic [31:0]        sval_d;
  logic [2:0]         inflight;

  assign inflight = {2'd0, s1_vld_q} + {2'd0, s2_vld_q} + qstat_i.level;
  assign full_o   = inflight >= 3'(QDEPTH);
  assign acc      = push_i && !full_o;
  assign x        = activation_bits_i;

  always_comb begin
    case (fmt_i)
      FMT_BF16: w = {weight_word_i[15:0], 16'd0};
      FMT_HALF: w = half_to_single(weight_word_i[15:0]);
      default:  w = weight_word_i;
    endcase
    spec_d = 1'b1;
    sval_d = 32'd0;
    if (is_nan(w) || is_nan(x)) begin
      sval_d = QNAN_BITS;
    end else if (is_inf(w) || is_inf(x)) begin
      sval_d = (is_zero(w) || is_zero(x)) ? QNAN_BITS : {w[31] ^ x[31], INF_BITS[30:0]};
    end else if (is_zero(w) || is_zero(x)) begin
      sval_d = {w[31] ^ x[31], 31'd0};
    end else begin
      spec_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= acc;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_spec_q <= spec_d;
      s1_sval_q <= sval_d;
      s1_sign_q <= w[31] ^ x[31];
      s1_last_q <= row_end_i;
      s1_exp_q  <= 12'((w[30:23] == 8'd0) ? 8'd1 : w[30:23])
                 + 12'((x[30:23] == 8'd0) ? 8'd1 : x[30:23]) - 12'sd150;
      s1_sig_q  <= {24'd0, w[30:23] != 8'd0, w[22:0]}
                 * {24'd0, x[30:23] != 8'd0, x[22:0]};
    end
    if (s1_vld_q) begin
      s2_q.last <= s1_last_q;
      s2_q.prod <= s1_spec_q ? s1_sval_q
                             : round_pack(s1_sign_q, s1_exp_q, {16'd0, s1_sig_q});
    end
  end

  assign qpush_o = s2_vld_q;
  assign qitem_o = s2_q;

endmodule

// ===== hw/rtl/mfrdp_queue.sv =====
// Product queue between front and back ends.
// Four entries; depends on mfrdp_pkg.
module mfrdp_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  mfrdp_pkg::prod_item_t  item_i,
  input  logic                   pop_i,
  output logic                   vld_o,
  output mfrdp_pkg::prod_item_t  item_o,
  output mfrdp_pkg::queue_stat_t stat_o
);
  import mfrdp_pkg::*;

  prod_item_t mem_q [QDEPTH];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       do_pop;

  assign vld_o        = cnt_q != 3'd0;
  assign do_pop       = pop_i && vld_o;
  assign item_o       = mem_q[rp_q];
  assign stat_o.level = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (do_pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, push_i} - {2'd0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

endmodule

// ===== hw/rtl/mfrdp_back.sv =====
// Back end: binary32 accumulate and two-entry result queue.
// Depends on mfrdp_pkg.
module mfrdp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  qvld_i,
  input  mfrdp_pkg::prod_item_t qitem_i,
  output logic                  qpop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [31:0]           dot_bits_o
);
  import mfrdp_pkg::*;

  logic [31:0] acc_q;
  logic [31:0] sum;
  logic [31:0] res_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        take, opush, opop;

  assign qpop_o     = cnt_q != 2'd2;
  assign take       = qvld_i && qpop_o;
  assign sum        = fadd(acc_q, qitem_i.prod);
  assign opush      = take && qitem_i.last;
  assign empty_o    = cnt_q == 2'd0;
  assign opop       = pop_i && !empty_o;
  assign dot_bits_o = res_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 32'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (take) acc_q <= qitem_i.last ? 32'd0 : sum;
      if (opush) wp_q <= !wp_q;
      if (opop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, opush} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) res_q[wp_q] <= sum;
  end

endmodule

// ===== hw/rtl/mixed_format_row_dot_product_unit.sv =====
// Top level of the mixed-format row dot product unit.
// Path: a row_end item passes both front-end stages and the product queue, then its sum enters the result queue.
// Throughput: one item per cycle while the result queue has room; the accumulate add in the back end sets the rate.
// Reset: asynchronous, active low; clears the accumulator, the queues and
// weight_format (binary32). Depends on mfrdp_pkg and the mfrdp_* modules.
module mixed_format_row_dot_product_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] weight_word_i,
  input  logic [31:0] activation_bits_i,
  input  logic        row_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] dot_bits_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mfrdp_pkg::*;

  logic [1:0]  fmt_q;
  logic        qpush, qpop, qvld;
  prod_item_t  qin, qout;
  queue_stat_t qstat;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, fmt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_FP32;
    end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
      fmt_q <= pwdata[1:0];
    end
  end

  mfrdp_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .weight_word_i, .activation_bits_i, .row_end_i,
    .fmt_i(fmt_q), .qstat_i(qstat),
    .qpush_o(qpush), .qitem_o(qin)
  );

  mfrdp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(qpush), .item_i(qin),
    .pop_i(qpop), .vld_o(qvld), .item_o(qout), .stat_o(qstat)
  );

  mfrdp_back u_back (
    .clk_i, .rst_ni,
    .qvld_i(qvld), .qitem_i(qout), .qpop_o(qpop),
    .empty_o(empty), .pop_i(pop), .dot_bits_o
  );

endmodule

// ===== hw/rtl/mfrdp_checker.sv =====
// Port-level checker for the mixed-format row dot product unit.
// Bound to mixed_format_row_dot_product_unit; no other dependencies.
module mfrdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] dot_bits_o,
  input logic [1:0]  paddr,
  input logic [31:0] prdata,
  input logic        pready
);

  a_empty_after_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("result queue not empty after reset");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(dot_bits_o)))
    else $error("waiting result changed");

  a_prdata_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[31:2] == 30'd0 && (paddr == 2'd0 || prdata == 32'd0))
    else $error("read data out of range");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind mixed_format_row_dot_product_unit mfrdp_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .dot_bits_o, .paddr, .prdata, .pready
);
